/* rtl/ida_pkg.sv */
// Package for the integer to decimal text converter.
// Holds the character codes, BCD digit types and sequencer states.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ida_pkg;

   localparam int VALUE_W   = 32;
   localparam int DIGITS    = 10;
   localparam int DIGIT_W   = 4;
   localparam int CHAR_W    = 8;
   localparam int IDX_W     = $clog2(DIGITS);
   localparam int CNT_W     = $clog2(VALUE_W);

   localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'd48;
   localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'd45;
   localparam logic [DIGIT_W-1:0] ADD_LIMIT  = 4'd5;
   localparam logic [DIGIT_W-1:0] ADD_FIX    = 4'd3;

   typedef logic [DIGIT_W-1:0] digit_type;
   typedef digit_type [DIGITS-1:0] bcd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_FIND,
      ST_SIGN,
      ST_EMIT
   } state_type;

endpackage

`default_nettype wire

/* rtl/ida_bcd_shift.sv */
// One step of the shift-and-add-three binary to BCD conversion.
// Corrects every digit that is five or more, then shifts one binary bit in.
// Depends on ida_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ida_bcd_shift
   import ida_pkg::*;
(
   input  bcd_type    bcd_cur,
   input  logic       bit_in,
   output bcd_type    bcd_nxt
);

   bcd_type adj;

   always_comb begin
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_cur[i] >= ADD_LIMIT) begin
            adj[i] = bcd_cur[i] + ADD_FIX;
         end else begin
            adj[i] = bcd_cur[i];
         end
      end
      bcd_nxt[0] = {adj[0][DIGIT_W-2:0], bit_in};
      for (int i = 1; i < DIGITS; i++) begin
         bcd_nxt[i] = {adj[i][DIGIT_W-2:0], adj[i-1][DIGIT_W-1]};
      end
   end

endmodule

`default_nettype wire

/* rtl/int_to_decimal_ascii.sv */
// Top level of the signed 32-bit integer to decimal ASCII text converter.
// Depends on ida_pkg and ida_bcd_shift.
//
// Usage:
// A value is transferred on req_value at a rising edge where start is high
// and busy is low. The block then converts the magnitude to ten BCD digits,
// one bit per cycle through a shared shift-and-add-three unit. ST_FIND
// then locates the leading non-zero digit. The text is then sent most
// significant character first, one character per cycle on rsp_char_code
// with rsp_valid high for that cycle only: a '-' for a negative value,
// then the digits without leading zeros. rsp_last marks the final
// character of the run. busy stays high from the transfer until the final
// character goes onto the outputs. A new value may be transferred while
// the final character is on the outputs. The receiver cannot stall, so
// every character is taken as shown.
// Reset returns the block to idle and discards any run in progress.
`timescale 1ns / 1ps
`default_nettype none

module int_to_decimal_ascii
   import ida_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [VALUE_W-1:0] req_value,
   output logic                      rsp_valid,
   output logic        [CHAR_W-1:0]  rsp_char_code,
   output logic                      rsp_last
);

   state_type          state_ff, state_in;
   logic [VALUE_W-1:0] mag_ff, mag_in;
   logic               neg_ff, neg_in;
   bcd_type            bcd_ff, bcd_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               valid_ff, valid_in;
   logic [CHAR_W-1:0]  char_ff, char_in;
   logic               last_ff, last_in;

   bcd_type            bcd_step;
   logic [IDX_W-1:0]   lead_idx;

   ida_bcd_shift u_shift (
      .bcd_cur (bcd_ff),
      .bit_in  (mag_ff[VALUE_W-1]),
      .bcd_nxt (bcd_step)
   );

   always_comb begin
      lead_idx = '0;
      for (int i = 0; i < DIGITS; i++) begin
         if (bcd_ff[i] != '0) begin
            lead_idx = IDX_W'(i);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      mag_ff  <= mag_in;
      neg_ff  <= neg_in;
      bcd_ff  <= bcd_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      char_ff <= char_in;
      last_ff <= last_in;
   end

   always_comb begin
      state_in = state_ff;
      mag_in   = mag_ff;
      neg_in   = neg_ff;
      bcd_in   = bcd_ff;
      cnt_in   = cnt_ff;
      idx_in   = idx_ff;
      valid_in = 1'b0;
      char_in  = char_ff;
      last_in  = last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               neg_in   = req_value[VALUE_W-1];
               mag_in   = req_value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(req_value))
                                               : VALUE_W'(req_value);
               bcd_in   = '0;
               cnt_in   = '0;
               state_in = ST_CONVERT;
            end
         end
         ST_CONVERT: begin
            bcd_in = bcd_step;
            mag_in = {mag_ff[VALUE_W-2:0], 1'b0};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(VALUE_W - 1)) begin
               state_in = ST_FIND;
            end
         end
         ST_FIND: begin
            idx_in   = lead_idx;
            state_in = neg_ff ? ST_SIGN : ST_EMIT;
         end
         ST_SIGN: begin
            valid_in = 1'b1;
            char_in  = CHAR_MINUS;
            last_in  = 1'b0;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            valid_in = 1'b1;
            char_in  = CHAR_ZERO + CHAR_W'(bcd_ff[idx_ff]);
            last_in  = (idx_ff == '0);
            idx_in   = idx_ff - 1'b1;
            if (idx_ff == '0) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = valid_ff;
   assign rsp_char_code = char_ff;
   assign rsp_last      = last_ff;

endmodule

`default_nettype wire

/* dv/tb.sv */
// Self-checking testbench for int_to_decimal_ascii: signed 32-bit values in, decimal text out.
// Corner values and random values of every length are checked character by character.
// Depends on ida_pkg and the int_to_decimal_ascii RTL.
`timescale 1ns / 1ps

module tb;
   import ida_pkg::*;

   localparam int PERIOD       = 12;
   localparam int RESET_CYCLES = 6;
   localparam int RANDOM_ITEMS = 200;
   localparam int QUIET_LIMIT  = 2000;
   localparam int TAIL_CYCLES  = 60;
   localparam int RADIX        = 10;
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
   } glyph_type;

   logic                      clock     = 1'b0;
   logic                      reset     = 1'b1;
   logic                      start     = 1'b0;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic                      busy;
   logic                      rsp_valid;
   logic        [CHAR_W-1:0]  rsp_char_code;
   logic                      rsp_last;

   logic signed [VALUE_W-1:0] value_q[$];
   glyph_type                 glyph_q[$];
   logic                      took_value = 1'b0;
   int                        total_values = 0;
   int                        values_sent = 0;
   int                        values_taken = 0;
   int                        negatives_taken = 0;
   int                        glyphs_checked = 0;
   int                        mismatches = 0;
   int                        quiet_cycles = 0;

   int_to_decimal_ascii dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_char_code (rsp_char_code),
      .rsp_last      (rsp_last)
   );

   always #(PERIOD / 2) clock = ~clock;

   function automatic void spell_decimal(input logic signed [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] mag;
      logic [CHAR_W-1:0]  digs[$];
      mag = v[VALUE_W-1] ? (~v + 1'b1) : v;
      do begin
         digs.push_front(CHAR_ZERO + CHAR_W'(mag % RADIX));
         mag = mag / RADIX;
      end while (mag != 0);
      if (v[VALUE_W-1]) begin
         glyph_q.push_back('{code: CHAR_MINUS, last: 1'b0});
      end
      foreach (digs[i]) begin
         glyph_q.push_back('{code: digs[i], last: (i == digs.size() - 1)});
      end
   endfunction

   function automatic logic signed [VALUE_W-1:0] random_value();
      longint lo;
      longint hi;
      longint mag;
      int     ndig;
      if ($urandom_range(7) == 0) begin
         return $urandom;
      end
      ndig = $urandom_range(1, DIGITS);
      lo = (ndig == 1) ? 0 : 64'd10 ** (ndig - 1);
      hi = 64'd10 ** ndig - 1;
      if (hi > 64'sd2147483647) begin
         hi = 64'sd2147483647;
      end
      mag = lo + ({$urandom, $urandom} % (hi - lo + 1));
      if ($urandom_range(1)) begin
         mag = -mag;
      end
      return mag[VALUE_W-1:0];
   endfunction

   function automatic int sender_idle_pct();
      if (values_sent < total_values / 3) begin
         return 9;
      end else if (values_sent < 2 * total_values / 3) begin
         return 58;
      end
      return 0;
   endfunction

   // The sender holds a value until it is transferred, and only then moves to the next one.
   always @(negedge clock) begin
      if (!reset && (!start || took_value)) begin
         if (value_q.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
            start     <= 1'b1;
            req_value <= value_q.pop_front();
            values_sent++;
         end else begin
            start     <= 1'b0;
            req_value <= $urandom;
         end
      end
   end

   always @(posedge clock) begin
      took_value <= !reset && start && !busy;
      if (!reset) begin
         if (rsp_valid) begin
            if (glyph_q.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX) begin
                  $display("tb: unexpected character %0d last %0b at %0t",
                           rsp_char_code, rsp_last, $realtime);
               end
            end else begin
               glyph_type want;
               want = glyph_q.pop_front();
               glyphs_checked++;
               if (rsp_char_code !== want.code || rsp_last !== want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX) begin
                     $display("tb: mismatch at %0t: expected char %0d last %0b, got %0d last %0b",
                              $realtime, want.code, want.last, rsp_char_code, rsp_last);
                  end
               end
            end
         end
         if (start && !busy) begin
            spell_decimal(req_value);
            values_taken++;
            if (req_value < 0) begin
               negatives_taken++;
            end
         end
         if ((start && !busy) || rsp_valid) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
               $display("tb: no transfer for %0d cycles, %0d characters still due",
                        QUIET_LIMIT, glyph_q.size());
               $display("tb: FAIL");
               $finish;
            end
         end
      end
   end

   initial begin
      logic signed [VALUE_W-1:0] corner[$] = '{
         0, 1, -1, 9, -9, 10, -10, 99, 100, -100, 12345, -54321,
         999999999, -999999999, 1000000000, -1000000000, 1234567890, -1234567890,
         32'sh7FFFFFFF, 32'sh80000001, 32'sh80000000, 32'sh55555555, 32'shAAAAAAAA
      };
      foreach (corner[i]) begin
         value_q.push_back(corner[i]);
      end
      repeat (RANDOM_ITEMS) begin
         value_q.push_back(random_value());
      end
      total_values = value_q.size();
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      wait (values_taken == total_values);
      wait (glyph_q.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      $display("tb: %0d values converted (%0d negative, extremes included), %0d characters checked",
               values_taken, negatives_taken, glyphs_checked);
      $display("tb: sender gaps ran at 9, 58 and 0 percent; %0d mismatches", mismatches);
      if (mismatches == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
